// File: hw/rtl/uv_lamp_fault_monitor_defines.svh
// Assertion macros for the lamp fault monitor checkers.
`ifndef UV_LAMP_FAULT_MONITOR_DEFINES_SVH
`define UV_LAMP_FAULT_MONITOR_DEFINES_SVH

// Checked only while out of reset.
`define UVLFM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define UVLFM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/uvlfm_pkg.sv
package uvlfm_pkg;

  // Config port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Depth of the job and result queues
  localparam int Q_DEPTH = 2;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OVER_TH  = 3'd0,
    REG_UNDER_TH = 3'd1,
    REG_CHECK    = 3'd2,
    REG_RETRY    = 3'd3,
    REG_WAIT     = 3'd4
  } cfg_reg_t;

  // Reset values of the registers
  localparam logic [9:0] OVER_TH_RST  = 10'd1000;
  localparam logic [9:0] UNDER_TH_RST = 10'd20;
  localparam logic [7:0] CHECK_RST    = 8'd10;
  localparam logic [7:0] RETRY_RST    = 8'd3;
  localparam logic [7:0] WAIT_RST     = 8'd30;

  typedef struct packed {
    logic [9:0] over_threshold;
    logic [9:0] under_threshold;
    logic [7:0] check_ticks;
    logic [7:0] retry_limit;
    logic [7:0] retry_wait;
  } cfg_t;

  // Input beat
  typedef struct packed {
    logic [2:0] channel;
    logic       drive_on;
    logic [9:0] current_sample;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic fault;
    logic retry_paused;
    logic cleared_now;
  } out_beat_t;

  // Classified job handed from front to back
  typedef struct packed {
    logic       ch_ok;
    logic [2:0] channel;
    logic       drive_on;
    logic       out_win;
  } job_t;

  // Per-channel monitor state
  typedef struct packed {
    logic [7:0] bad_timer;
    logic [7:0] good_timer;
    logic [7:0] failure_count;
    logic [7:0] pause_timer;
    logic       pause_flag;
    logic       fault_flag;
  } chan_st_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

// File: hw/rtl/uv_lamp_fault_monitor.sv
// UV lamp current fault monitor. Each tick beat (channel, drive_on, current sample)
// yields exactly one result beat (fault, retry_paused, cleared_now) giving that
// channel's state after the tick; results leave in input order. Throughput is one
// beat per cycle while results are popped and no queue is full. When nothing stalls,
// the result of a beat accepted at one clock edge is on the result ports right after
// the next edge and can be popped there. The result path runs through the back
// end's read-modify-write of the per-channel state table, which sits between
// a two-entry job queue and a two-entry result queue. Channels at or above CHANNELS
// change nothing and report all zeros. The user must write registers through the
// cfg port only while no beat is in flight; the block does not enforce this. Indexes
// 0..4 are over/under threshold, check ticks, retry limit, retry wait.
module uv_lamp_fault_monitor import uvlfm_pkg::*; #(
  parameter int CHANNELS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  in_beat_t              in_data,
  output logic                  empty,
  input  logic                  pop,
  output out_beat_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int JOB_W = $bits(job_t);
  localparam int RES_W = $bits(out_beat_t);

  cfg_t             cfg_r;
  job_t             job_in, job_out;
  logic [JOB_W-1:0] job_q_rdata;
  logic             job_empty, job_pop;
  out_beat_t        res;
  logic [RES_W-1:0] res_q_rdata;
  logic             res_push, res_full;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.over_threshold  <= OVER_TH_RST;
      cfg_r.under_threshold <= UNDER_TH_RST;
      cfg_r.check_ticks     <= CHECK_RST;
      cfg_r.retry_limit     <= RETRY_RST;
      cfg_r.retry_wait      <= WAIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_OVER_TH:  cfg_r.over_threshold  <= cfg_wdata;
        REG_UNDER_TH: cfg_r.under_threshold <= cfg_wdata;
        REG_CHECK:    cfg_r.check_ticks     <= cfg_wdata[7:0];
        REG_RETRY:    cfg_r.retry_limit     <= cfg_wdata[7:0];
        REG_WAIT:     cfg_r.retry_wait      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  uvlfm_front #(.CHANNELS(CHANNELS)) u_front (
    .cfg     (cfg_r),
    .in_data (in_data),
    .job     (job_in)
  );

  uvlfm_fifo #(.WIDTH(JOB_W), .DEPTH(Q_DEPTH)) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (job_in),
    .full  (full),
    .pop   (job_pop),
    .rdata (job_q_rdata),
    .empty (job_empty)
  );

  assign job_out = job_t'(job_q_rdata);

  uvlfm_back #(.CHANNELS(CHANNELS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job       (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .res       (res),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  uvlfm_fifo #(.WIDTH(RES_W), .DEPTH(Q_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_q_rdata),
    .empty (empty)
  );

  assign out_data = out_beat_t'(res_q_rdata);

endmodule

// File: hw/rtl/uvlfm_fifo.sv
// Small synchronous queue, registered flags, one push (while not full) and one pop (while not empty) per cycle.
module uvlfm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: hw/rtl/uvlfm_front.sv
// Front end: range-checks the channel and classifies the sample window.
module uvlfm_front import uvlfm_pkg::*; #(
  parameter int CHANNELS = 6
) (
  input  cfg_t     cfg,
  input  in_beat_t in_data,
  output job_t     job
);

  logic [31:0] ch_ext;

  assign ch_ext = 32'(in_data.channel);

  always_comb begin
    job.ch_ok    = (ch_ext < 32'(CHANNELS));
    job.channel  = in_data.channel;
    job.drive_on = in_data.drive_on;
    // Out of window if either bound trips; overlapping bounds just OR
    job.out_win  = (in_data.current_sample >= cfg.over_threshold) ||
                   (in_data.current_sample <= cfg.under_threshold);
  end

endmodule

// File: hw/rtl/uvlfm_back.sv
// Back end: read-modify-write of the per-channel state, written back when a job fires.
module uvlfm_back import uvlfm_pkg::*; #(
  parameter int CHANNELS = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  job_t      job,
  input  logic      job_empty,
  output logic      job_pop,
  output out_beat_t res,
  output logic      res_push,
  input  logic      res_full
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  chan_st_t         st_r [CHANNELS];
  chan_st_t         cur, upd;
  logic [31:0]      ch_ext;
  logic [IDX_W-1:0] idx;
  logic             fire;
  logic             cleared;
  logic [7:0]       b1, g1, f1, p1;

  assign ch_ext   = 32'(job.channel);
  assign idx      = ch_ext[IDX_W-1:0];
  assign fire     = !job_empty && !res_full;
  assign job_pop  = fire;
  assign res_push = fire;
  assign cur      = job.ch_ok ? st_r[idx] : '0;

  // Channel state update
  always_comb begin
    upd     = cur;
    cleared = 1'b0;
    b1      = sat_inc(cur.bad_timer);
    g1      = sat_inc(cur.good_timer);
    f1      = sat_inc(cur.failure_count);
    p1      = sat_inc(cur.pause_timer);
    if (job.drive_on && !cur.pause_flag) begin
      if (job.out_win) begin
        upd.good_timer = '0;
        upd.bad_timer  = b1;
        if (b1 >= cfg.check_ticks) begin
          if (f1 >= cfg.retry_limit) begin
            // retries used up: latch the fault
            upd.failure_count = cfg.retry_limit;
            upd.bad_timer     = cfg.check_ticks;
            upd.fault_flag    = 1'b1;
          end else begin
            upd.failure_count = f1;
            upd.bad_timer     = '0;
            upd.pause_flag    = 1'b1;
          end
        end
      end else begin
        upd.bad_timer  = '0;
        upd.good_timer = g1;
        if (g1 >= cfg.check_ticks) begin
          // good run complete: clear fault and retries
          upd.good_timer    = cfg.check_ticks;
          cleared           = cur.fault_flag;
          upd.fault_flag    = 1'b0;
          upd.failure_count = '0;
        end
      end
    end else begin
      upd.good_timer = '0;
      upd.bad_timer  = '0;
      if (cur.pause_flag) begin
        upd.pause_timer = p1;
        if (p1 >= cfg.retry_wait) begin
          upd.pause_timer = '0;
          upd.pause_flag  = 1'b0;
        end
      end else begin
        upd.pause_timer   = '0;
        upd.failure_count = '0;
      end
    end
  end

  // Result beat; out-of-range channels report all zero
  always_comb begin
    res.fault        = job.ch_ok && upd.fault_flag;
    res.retry_paused = job.ch_ok && upd.pause_flag;
    res.cleared_now  = job.ch_ok && cleared;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        st_r[i] <= '0;
      end
    end else if (fire && job.ch_ok) begin
      st_r[idx] <= upd;
    end
  end

endmodule

// File: hw/rtl/uvlfm_checker.sv
`include "uv_lamp_fault_monitor_defines.svh"

// Port-level checks for the lamp fault monitor.
module uvlfm_checker import uvlfm_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  push,
  input logic                  full,
  input in_beat_t              in_data,
  input logic                  empty,
  input logic                  pop,
  input out_beat_t             out_data,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_idx,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic clr_dirty;
  logic acc_idle;
  logic out_stall;

  // cleared beat that still carries fault or pause
  assign clr_dirty = out_data.cleared_now && (out_data.fault || out_data.retry_paused);
  // beat accepted while the result side is idle
  assign acc_idle  = push && !full && empty && !pop;
  // result beat waiting, not taken
  assign out_stall = !empty && !pop;

  // Reset drains the result side
  `UVLFM_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> empty, "result queue not empty after reset")

  // A clear only happens from a good run, so fault is down and no pause
  `UVLFM_ASSERT(a_clear_clean, !empty |-> !clr_dirty, "cleared beat still shows fault or pause")

  // With an idle result side, an accepted beat's result is up right after the next edge
  `UVLFM_ASSERT(a_latency, acc_idle |-> ##2 !empty, "result missing after accept")

  // A stalled result beat holds
  `UVLFM_ASSERT(a_out_hold, out_stall |=> !empty && $stable(out_data), "stalled beat changed")

endmodule

bind uv_lamp_fault_monitor uvlfm_checker u_chk (.*);

// File: test/uv_lamp_fault_monitor_tb.sv
module uv_lamp_fault_monitor_tb;
  import uvlfm_pkg::*;

  localparam int NUM_CH = 6;

  // Per-channel lamp monitor predictor plus the queue of results it expects
  class lamp_scoreboard;
    cfg_t       regs;
    logic [7:0] bad_t   [NUM_CH];
    logic [7:0] good_t  [NUM_CH];
    logic [7:0] fail_n  [NUM_CH];
    logic [7:0] pause_t [NUM_CH];
    logic       pause_f [NUM_CH];
    logic       fault_f [NUM_CH];
    out_beat_t  due [$];
    int         fails;
    int         beats;
    int         faults_seen;
    int         clears_seen;
    int         pauses_seen;

    function new();
      regs = '{over_threshold: OVER_TH_RST, under_threshold: UNDER_TH_RST,
               check_ticks: CHECK_RST, retry_limit: RETRY_RST, retry_wait: WAIT_RST};
      foreach (bad_t[i]) begin
        bad_t[i]   = '0;
        good_t[i]  = '0;
        fail_n[i]  = '0;
        pause_t[i] = '0;
        pause_f[i] = 1'b0;
        fault_f[i] = 1'b0;
      end
    endfunction

    // 8-bit counters stick at 255
    function logic [7:0] bump(input logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function void set_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_OVER_TH:  regs.over_threshold  = val;
        REG_UNDER_TH: regs.under_threshold = val;
        REG_CHECK:    regs.check_ticks     = val[7:0];
        REG_RETRY:    regs.retry_limit     = val[7:0];
        REG_WAIT:     regs.retry_wait      = val[7:0];
        default: ;
      endcase
    endfunction

    // Advance one channel by one tick and queue the state it should report
    function void note_tick(input in_beat_t b);
      int unsigned ch;
      out_beat_t   r;
      ch = b.channel;
      r  = '0;
      if (ch < NUM_CH) begin
        if (b.drive_on && !pause_f[ch]) begin
          if (b.current_sample >= regs.over_threshold ||
              b.current_sample <= regs.under_threshold) begin
            good_t[ch] = '0;
            bad_t[ch]  = bump(bad_t[ch]);
            if (bad_t[ch] >= regs.check_ticks) begin
              fail_n[ch] = bump(fail_n[ch]);
              if (fail_n[ch] >= regs.retry_limit) begin
                fail_n[ch]  = regs.retry_limit;
                bad_t[ch]   = regs.check_ticks;
                fault_f[ch] = 1'b1;
              end else begin
                bad_t[ch]   = '0;
                pause_f[ch] = 1'b1;
              end
            end
          end else begin
            bad_t[ch]  = '0;
            good_t[ch] = bump(good_t[ch]);
            if (good_t[ch] >= regs.check_ticks) begin
              good_t[ch] = regs.check_ticks;
              if (fault_f[ch]) r.cleared_now = 1'b1;
              fault_f[ch] = 1'b0;
              fail_n[ch]  = '0;
            end
          end
        end else begin
          // lamp off or paused: run timers restart
          good_t[ch] = '0;
          bad_t[ch]  = '0;
          if (pause_f[ch]) begin
            pause_t[ch] = bump(pause_t[ch]);
            if (pause_t[ch] >= regs.retry_wait) begin
              pause_t[ch] = '0;
              pause_f[ch] = 1'b0;
            end
          end else begin
            pause_t[ch] = '0;
            fail_n[ch]  = '0;
          end
        end
        r.fault        = fault_f[ch];
        r.retry_paused = pause_f[ch];
      end
      due.push_back(r);
    endfunction

    function void check_result(input out_beat_t got);
      out_beat_t want;
      if (due.size() == 0) begin
        $error("result beat with nothing expected: %b", got);
        fails++;
        return;
      end
      want = due.pop_front();
      beats++;
      faults_seen += want.fault;
      clears_seen += want.cleared_now;
      pauses_seen += want.retry_paused;
      if (got.fault !== want.fault) begin
        $error("fault mismatch: expected %0b, actual %0b", want.fault, got.fault);
        fails++;
      end
      if (got.retry_paused !== want.retry_paused) begin
        $error("retry_paused mismatch: expected %0b, actual %0b",
               want.retry_paused, got.retry_paused);
        fails++;
      end
      if (got.cleared_now !== want.cleared_now) begin
        $error("cleared_now mismatch: expected %0b, actual %0b",
               want.cleared_now, got.cleared_now);
        fails++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  in_beat_t              in_data = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  lamp_scoreboard sb;
  bit             calm = 1'b0;
  int unsigned    hot_ch = 0;
  int unsigned    hot_pct = 50;
  bit             bad_trend [8];
  int             settings_n = 0;

  uv_lamp_fault_monitor #(.CHANNELS(NUM_CH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Gap taken with roughly 37 percent probability, never while calm
  function automatic bit take_gap();
    return !calm && ($urandom_range(99) < 37);
  endfunction

  // Watch both handshakes; pop stalls at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) sb.note_tick(in_data);
      if (pop && !empty) sb.check_result(out_data);
    end
    pop <= !take_gap();
  end

  task automatic send_beat(input in_beat_t b);
    while (take_gap()) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Wait until every expected result is back, then let the pipe settle
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic write_regs(input cfg_t c);
    put_reg(REG_OVER_TH, c.over_threshold);
    put_reg(REG_UNDER_TH, c.under_threshold);
    put_reg(REG_CHECK, c.check_ticks);
    put_reg(REG_RETRY, c.retry_limit);
    put_reg(REG_WAIT, c.retry_wait);
    cfg_we <= 1'b0;
    settings_n++;
  endtask

  function automatic in_beat_t tick(input int unsigned ch, input bit drv,
                                    input int unsigned smp);
    in_beat_t b;
    b.channel        = 3'(ch);
    b.drive_on       = drv;
    b.current_sample = 10'(smp);
    return b;
  endfunction

  // Sample biased toward in-window or out-of-window, with edges and noise
  function automatic logic [9:0] pick_sample(input bit want_bad);
    int lo;
    int hi;
    int roll;
    lo   = sb.regs.under_threshold;
    hi   = sb.regs.over_threshold;
    roll = $urandom_range(99);
    if (roll < 8) begin
      case ($urandom_range(3))
        0:       return 10'(lo);
        1:       return 10'(lo + 1);
        2:       return 10'(hi);
        default: return 10'(hi - 1);
      endcase
    end
    if (roll < 15) return 10'($urandom);
    if (want_bad) begin
      if ($urandom_range(1)) return 10'($urandom_range(1023, hi));
      return 10'($urandom_range(lo, 0));
    end
    if (lo + 1 <= hi - 1) return 10'($urandom_range(hi - 1, lo + 1));
    return 10'($urandom);
  endfunction

  // Per-channel good/bad runs so timers actually reach their limits
  function automatic in_beat_t random_beat();
    in_beat_t    b;
    int unsigned ch;
    if ($urandom_range(99) < 3) ch = $urandom_range(7, NUM_CH);
    else if ($urandom_range(99) < hot_pct) ch = hot_ch;
    else ch = $urandom_range(NUM_CH - 1);
    if ($urandom_range(99) < 15) bad_trend[ch] = !bad_trend[ch];
    b.channel        = 3'(ch);
    b.drive_on       = ($urandom_range(99) < 90);
    b.current_sample = pick_sample(bad_trend[ch]);
    return b;
  endfunction

  // Run limit
  initial begin
    #2000000;
    $display("uv_lamp_fault_monitor test failed");
    $finish;
  end

  initial begin
    cfg_t     plan [$];
    int       lens [$];
    in_beat_t directed [$];
    cfg_t     c;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: short limits so one channel walks through fail, pause, latch, clear
    c = '{over_threshold: 10'd600, under_threshold: 10'd100,
          check_ticks: 8'd2, retry_limit: 8'd2, retry_wait: 8'd2};
    write_regs(c);
    directed = '{tick(0, 1, 0), tick(0, 1, 1023), tick(0, 1, 500), tick(0, 0, 500),
                 tick(0, 1, 100), tick(0, 1, 600), tick(0, 1, 101), tick(0, 1, 599),
                 tick(0, 1, 300), tick(0, 1, 350), tick(6, 1, 0), tick(7, 1, 1023),
                 tick(7, 0, 0), tick(5, 1, 1023), tick(5, 0, 0), tick(5, 1, 1023),
                 tick(3, 0, 1023), tick(4, 1, 512), tick(4, 1, 511), tick(2, 1, 0),
                 tick(2, 1, 0), tick(1, 1, 0), tick(1, 0, 700)};
    foreach (directed[i]) send_beat(directed[i]);
    drain();

    // Register settings for the random part, extremes first
    plan.push_back('{over_threshold: 10'd1023, under_threshold: 10'd0,
                     check_ticks: 8'd1, retry_limit: 8'd1, retry_wait: 8'd1});
    lens.push_back(150);
    plan.push_back('{over_threshold: 10'd0, under_threshold: 10'd1023,
                     check_ticks: 8'd255, retry_limit: 8'd255, retry_wait: 8'd255});
    lens.push_back(500);
    // overlapping thresholds
    plan.push_back('{over_threshold: 10'd300, under_threshold: 10'd700,
                     check_ticks: 8'd3, retry_limit: 8'd2, retry_wait: 8'd5});
    lens.push_back(150);
    // zero limits confirm, latch and unpause at once
    plan.push_back('{over_threshold: 10'd900, under_threshold: 10'd50,
                     check_ticks: 8'd0, retry_limit: 8'd0, retry_wait: 8'd0});
    lens.push_back(120);
    repeat (3) begin
      c.over_threshold  = 10'($urandom_range(1023, 500));
      c.under_threshold = 10'($urandom_range(400, 0));
      c.check_ticks     = 8'($urandom_range(8, 1));
      c.retry_limit     = 8'($urandom_range(5, 1));
      c.retry_wait      = 8'($urandom_range(10, 1));
      plan.push_back(c);
      lens.push_back(150);
    end
    plan.push_back('{over_threshold: OVER_TH_RST, under_threshold: UNDER_TH_RST,
                     check_ticks: CHECK_RST, retry_limit: RETRY_RST, retry_wait: WAIT_RST});
    lens.push_back(250);

    for (int p = 0; p < plan.size(); p++) begin
      write_regs(plan[p]);
      hot_ch  = $urandom_range(NUM_CH - 1);
      hot_pct = (p == 1) ? 60 : 50;
      calm    = (p == 6);
      for (int i = 0; i < lens[p]; i++) send_beat(random_beat());
      drain();
    end
    calm = 1'b0;

    if (sb.due.size() != 0) begin
      $error("%0d expected result beats never arrived", sb.due.size());
      sb.fails++;
    end
    $display("Checked %0d result beats over %0d register settings", sb.beats, settings_n);
    $display("Results with fault set: %0d, clearing pulses: %0d, paused: %0d",
             sb.faults_seen, sb.clears_seen, sb.pauses_seen);
    if (sb.fails == 0) begin
      $display("uv_lamp_fault_monitor test passed");
    end else begin
      $display("uv_lamp_fault_monitor test failed");
    end
    $finish;
  end

endmodule

// File: uv_lamp_fault_monitor.f
+incdir+hw/rtl
hw/rtl/uvlfm_pkg.sv
hw/rtl/uvlfm_fifo.sv
hw/rtl/uvlfm_front.sv
hw/rtl/uvlfm_back.sv
hw/rtl/uv_lamp_fault_monitor.sv
hw/rtl/uvlfm_checker.sv
test/uv_lamp_fault_monitor_tb.sv
